[sv/rsp_packet_framer_core_defines.svh]
// assertion macros for the packet framer
`ifndef RSP_PACKET_FRAMER_CORE_DEFINES_SVH
`define RSP_PACKET_FRAMER_CORE_DEFINES_SVH

// checked on every clock edge outside reset
`define RSPF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked on every clock edge, reset included
`define RSPF_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

[sv/rspf_pkg.sv]
// shared constants, types and helpers of the packet framer
package rspf_pkg;

  // framing characters
  localparam logic [7:0] ChStart  = 8'h24;
  localparam logic [7:0] ChHash   = 8'h23;
  localparam logic [7:0] ChStar   = 8'h2A;
  localparam logic [7:0] ChEsc    = 8'h7D;
  localparam logic [7:0] ChBreak  = 8'h03;
  localparam logic [7:0] ChMaxRaw = 8'd126;
  localparam logic [7:0] EscXor   = 8'h20;

  // input item codes
  localparam logic ActPayload = 1'b0;
  localparam logic ActClose   = 1'b1;

  // most output beats one input beat can produce
  localparam int SeqDepth = 4;
  localparam int CntW     = $clog2(SeqDepth + 1);

  // one pending output beat
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       pend;
  } entry_t;

  typedef entry_t [SeqDepth-1:0] seq_t;

  // framing state carried between input beats
  typedef struct packed {
    logic       in_packet;
    logic [7:0] sum;
    logic [7:0] prev;
  } frame_state_t;

  // ascii hex digit of one nibble
  function automatic logic [7:0] hex_digit(input logic [3:0] nib, input logic upper);
    logic [7:0] base;
    base = upper ? 8'h41 : 8'h61;
    if (nib < 4'd10) begin
      hex_digit = 8'h30 + {4'b0, nib};
    end else begin
      hex_digit = base + {4'b0, nib} - 8'd10;
    end
  endfunction

endpackage

[sv/rsp_packet_framer_core.sv]
// top level of the remote-protocol packet framer
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+-------------------------------
//  cfg     | in        | cfg_valid_i/cfg_ready_o | cfg_data_i (hex_upper_case)
//  in      | in        | in_valid_i/in_ready_o   | action_i, data_byte_i
//  out     | out       | out_valid_o/out_ready_i | out_byte_o, last_o, packet_end_o
//
// each input beat is expanded combinationally and loaded into a four-entry beat queue;
// the output register then drains one beat per cycle while out_ready_i allows it,
// and an input beat yields from 1 to 4 output beats.
// a new input beat is taken while the queue is empty or in the cycle it hands over its final beat.
// reset clears the framing state, the queue and the output valid; stalls on
// the output hold the output register and the queue.
`include "rsp_packet_framer_core_defines.svh"

module rsp_packet_framer_core
  import rspf_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic       cfg_data_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       action_i,
  input  logic [7:0] data_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       last_o,
  output logic       packet_end_o
);

  logic            hex_upper_q;
  frame_state_t    state_q;
  frame_state_t    state_d;
  seq_t            seq_q;
  seq_t            seq_new;
  logic [CntW-1:0] cnt_q;
  logic [CntW-1:0] cnt_new;
  logic            out_valid_q;
  entry_t          out_q;
  logic            out_load;
  logic            pop;
  logic            in_acc;

  // config register, always writable
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hex_upper_q <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      hex_upper_q <= cfg_data_i;
    end
  end

  // handshake control
  assign out_load   = !out_valid_q || out_ready_i;
  assign pop        = out_load && (cnt_q != '0);
  assign in_ready_o = (cnt_q == '0) || ((cnt_q == CntW'(1)) && pop);
  assign in_acc     = in_valid_i && in_ready_o;

  // expansion of the incoming beat
  rspf_expand u_expand (
    .action_i    (action_i),
    .data_byte_i (data_byte_i),
    .hex_upper_i (hex_upper_q),
    .state_i     (state_q),
    .seq_o       (seq_new),
    .count_o     (cnt_new),
    .state_o     (state_d)
  );

  // framing state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (in_acc) begin
      state_q <= state_d;
    end
  end

  // beat queue: load on accept, shift on pop
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (in_acc) begin
      cnt_q <= cnt_new;
    end else if (pop) begin
      cnt_q <= cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      seq_q <= seq_new;
    end else if (pop) begin
      for (int i = 0; i < SeqDepth - 1; i++) begin
        seq_q[i] <= seq_q[i+1];
      end
      seq_q[SeqDepth-1] <= '0;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= (cnt_q != '0);
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      out_q <= seq_q[0];
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_byte_o   = out_q.data;
  assign last_o       = out_q.last;
  assign packet_end_o = out_q.pend;

  // checks
  `RSPF_ASSERT(a_pend_is_last, (out_valid_o && packet_end_o) |-> last_o, "packet end without last")
  `RSPF_ASSERT(a_acc_fills, in_acc |=> (cnt_q != '0), "accepted beat left queue empty")
  `RSPF_ASSERT(a_close_ends, (in_acc && (action_i == ActClose)) |=> !state_q.in_packet, "close left packet open")
  `RSPF_ASSERT_ALWAYS(a_rst_quiet, !rst_ni |-> !out_valid_o, "output valid in reset")

endmodule

[sv/rspf_expand.sv]
// expands one input beat into its output beats and the next framing state
module rspf_expand
  import rspf_pkg::*;
(
  input  logic              action_i,
  input  logic [7:0]        data_byte_i,
  input  logic              hex_upper_i,
  input  frame_state_t      state_i,
  output seq_t              seq_o,
  output logic [CntW-1:0]   count_o,
  output frame_state_t      state_o
);

  logic       start;
  logic [7:0] base_sum;
  logic [7:0] base_prev;
  logic [7:0] flipped;
  logic       special;
  logic       esc;
  logic [7:0] body [3];
  logic [CntW-1:0] nb;

  // per item body bytes and state update
  always_comb begin
    start     = !state_i.in_packet;
    base_sum  = state_i.in_packet ? state_i.sum  : 8'h00;
    base_prev = state_i.in_packet ? state_i.prev : 8'h00;
    flipped   = data_byte_i ^ EscXor;
    special   = (data_byte_i == ChStart) || (data_byte_i == ChHash) ||
                (data_byte_i == ChStar)  || (data_byte_i == ChEsc)  ||
                (data_byte_i == ChBreak);
    esc       = (special && (base_prev != ChStar)) || (data_byte_i > ChMaxRaw);
    body[0]   = 8'h00;
    body[1]   = 8'h00;
    body[2]   = 8'h00;
    nb        = '0;
    state_o   = '0;
    case (action_i)
      ActPayload: begin
        if (esc) begin
          body[0] = ChEsc;
          body[1] = flipped;
          nb      = CntW'(2);
          state_o = '{in_packet: 1'b1, sum: base_sum + ChEsc + flipped, prev: data_byte_i};
        end else begin
          body[0] = data_byte_i;
          nb      = CntW'(1);
          state_o = '{in_packet: 1'b1, sum: base_sum + data_byte_i, prev: data_byte_i};
        end
      end
      ActClose: begin
        body[0] = ChHash;
        body[1] = hex_digit(base_sum[7:4], hex_upper_i);
        body[2] = hex_digit(base_sum[3:0], hex_upper_i);
        nb      = CntW'(3);
        state_o = '0;
      end
      default: begin
        nb      = '0;
      end
    endcase
  end

  // place the body after an optional start character and mark the tail
  always_comb begin
    count_o = nb + CntW'(start);
    seq_o   = '0;
    if (start) begin
      seq_o[0].data = ChStart;
      seq_o[1].data = body[0];
      seq_o[2].data = body[1];
      seq_o[3].data = body[2];
    end else begin
      seq_o[0].data = body[0];
      seq_o[1].data = body[1];
      seq_o[2].data = body[2];
    end
    for (int i = 0; i < SeqDepth; i++) begin
      seq_o[i].last = (CntW'(i) == count_o - CntW'(1));
      seq_o[i].pend = seq_o[i].last && (action_i == ActClose);
    end
  end

endmodule
